[rtl/calrec_pkg.sv]
// calrec_pkg: shared types, constants and the crc-32 word update for the
// calibration record checker; no dependencies
package calrec_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'h4741_494E;
  localparam logic [31:0] REC_VERSION = 32'h0000_0001;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  localparam int unsigned GAIN_W = 14;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_RANGE       = 3'd3;
  localparam logic [2:0] ST_CRC         = 3'd4;

  // register indexes (word address bits)
  localparam logic [1:0] REG_GAIN_MIN     = 2'd0;
  localparam logic [1:0] REG_GAIN_MAX     = 2'd1;
  localparam logic [1:0] REG_GAIN_DEFAULT = 2'd2;

  // result handed from the core to the output stage
  typedef struct packed {
    logic        build;   // four-word build burst
    logic [31:0] word;    // chosen gain, or clamped gain when building
    logic [31:0] crc;     // record crc when building
    logic [2:0]  status;
  } result_t;

  // reflected crc-32 over one word, least significant bit first
  function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                           input logic [31:0] w);
    logic [31:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 32; i++) begin
      fb = c[0] ^ w[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

[rtl/calrec_core.sv]
// calrec_core: record check state (position, crc, first fault, gain) and
// build clamp; uses calrec_pkg
module calrec_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            op_i,
  input  logic [31:0]                     word_i,
  input  logic [calrec_pkg::GAIN_W-1:0]   gain_min_i,
  input  logic [calrec_pkg::GAIN_W-1:0]   gain_max_i,
  input  logic [calrec_pkg::GAIN_W-1:0]   gain_default_i,
  output logic                            has_result_o,
  output calrec_pkg::result_t             result_o
);

  logic [1:0]  pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [2:0]  fault_q, fault_d;
  logic [31:0] held_q, held_d;

  logic [31:0] min32, max32, def32;
  logic [31:0] gain_clamped;
  logic [31:0] crc_fold;
  logic [31:0] crc_build;
  logic        out_of_range;
  logic [2:0]  final_fault;

  assign min32 = 32'(gain_min_i);
  assign max32 = 32'(gain_max_i);
  assign def32 = 32'(gain_default_i);

  // floor tested first, so with inverted bounds a word under the floor takes the floor and any other word the ceiling
  always_comb begin
    if (word_i < min32) begin
      gain_clamped = min32;
    end else if (word_i > max32) begin
      gain_clamped = max32;
    end else begin
      gain_clamped = word_i;
    end
  end

  assign out_of_range = (word_i < min32) || (word_i > max32);
  assign crc_fold     = calrec_pkg::crc_word(crc_q, word_i);
  assign crc_build    = ~calrec_pkg::crc_word(
                          calrec_pkg::crc_word(
                            calrec_pkg::crc_word(calrec_pkg::CRC_INIT,
                                                 calrec_pkg::REC_MAGIC),
                            calrec_pkg::REC_VERSION),
                          gain_clamped);

  assign final_fault = (fault_q == calrec_pkg::ST_OK && ~crc_q != word_i) ?
                       calrec_pkg::ST_CRC : fault_q;

  always_comb begin
    pos_d             = pos_q;
    crc_d             = crc_q;
    fault_d           = fault_q;
    held_d            = held_q;
    has_result_o      = 1'b0;
    result_o.build    = op_i;
    result_o.word     = gain_clamped;
    result_o.crc      = crc_build;
    result_o.status   = calrec_pkg::ST_OK;
    if (op_i) begin
      has_result_o = 1'b1;
      pos_d        = 2'd0;
      crc_d        = calrec_pkg::CRC_INIT;
      fault_d      = calrec_pkg::ST_OK;
      held_d       = 32'd0;
    end else begin
      crc_d = crc_fold;
      pos_d = 2'(pos_q + 2'd1);
      unique case (pos_q)
        2'd0: begin
          if (fault_q == calrec_pkg::ST_OK && word_i != calrec_pkg::REC_MAGIC) begin
            fault_d = calrec_pkg::ST_BAD_MAGIC;
          end
        end
        2'd1: begin
          if (fault_q == calrec_pkg::ST_OK && word_i != calrec_pkg::REC_VERSION) begin
            fault_d = calrec_pkg::ST_BAD_VERSION;
          end
        end
        2'd2: begin
          held_d = word_i;
          if (fault_q == calrec_pkg::ST_OK && out_of_range) begin
            fault_d = calrec_pkg::ST_RANGE;
          end
        end
        default: begin
          has_result_o    = 1'b1;
          result_o.status = final_fault;
          result_o.word   = (final_fault == calrec_pkg::ST_OK) ? held_q : def32;
          pos_d           = 2'd0;
          crc_d           = calrec_pkg::CRC_INIT;
          fault_d         = calrec_pkg::ST_OK;
          held_d          = 32'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 2'd0;
      crc_q   <= calrec_pkg::CRC_INIT;
      fault_q <= calrec_pkg::ST_OK;
      held_q  <= 32'd0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      fault_q <= fault_d;
      held_q  <= held_d;
    end
  end

endmodule

[rtl/calrec_out.sv]
// calrec_out: result register and word sequencer for build bursts;
// uses calrec_pkg
module calrec_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_req_i,
  input  calrec_pkg::result_t  result_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          word_out_o,
  output logic [2:0]           status_o,
  output logic                 last_o
);

  logic                valid_q;
  logic [1:0]          beat_q;
  calrec_pkg::result_t res_q;
  logic                last_beat;
  logic                load;

  assign last_beat  = !res_q.build || (beat_q == 2'd3);
  assign can_load_o = !valid_q || (out_ready_i && last_beat);
  assign load       = load_req_i && can_load_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      beat_q  <= 2'd0;
    end else if (valid_q && out_ready_i) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        beat_q <= 2'(beat_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result_i;
    end
  end

  always_comb begin
    if (res_q.build) begin
      unique case (beat_q)
        2'd0:    word_out_o = calrec_pkg::REC_MAGIC;
        2'd1:    word_out_o = calrec_pkg::REC_VERSION;
        2'd2:    word_out_o = res_q.word;
        default: word_out_o = res_q.crc;
      endcase
      status_o = calrec_pkg::ST_OK;
    end else begin
      word_out_o = res_q.word;
      status_o   = res_q.status;
    end
  end

  assign out_valid_o = valid_q;
  assign last_o      = last_beat;

`ifndef ASSERT_OFF
  a_beat_only_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.build |-> beat_q == 2'd0)
    else $error("beat counter moved on a check result");

  a_fault_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != calrec_pkg::ST_OK |-> last_o)
    else $error("fault status on a non-final word");

  a_beat_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && beat_q == 2'($past(beat_q) + 2'd1))
    else $error("build burst did not advance");
`endif

endmodule

[rtl/calibration_record_crc_check.sv]
// calibration_record_crc_check: top level, apb registers, input register,
// check/build core (calrec_core) and output sequencer (calrec_out); uses calrec_pkg
// path: a word waits in the input register; the core takes it as it moves on
// and its result is offered from the result register in calrec_out
// throughput: one check word per cycle unless the output stage is full; a
// build holds the output for four words; reset spares data registers, no sweep
module calibration_record_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] word_in_i,
  // output word channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_out_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  // configuration registers
  logic [calrec_pkg::GAIN_W-1:0] gain_min_q;
  logic [calrec_pkg::GAIN_W-1:0] gain_max_q;
  logic [calrec_pkg::GAIN_W-1:0] gain_default_q;
  logic                          cfg_wr;

  // input register, parts the upstream handshake from the core
  logic        in_v_q;
  logic        op_q;
  logic [31:0] word_q;

  // core to output stage
  logic                has_result;
  calrec_pkg::result_t result;
  logic                can_load;
  logic                advance;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_min_q     <= 14'd1;
      gain_max_q     <= 14'd9999;
      gain_default_q <= 14'd100;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        calrec_pkg::REG_GAIN_MIN:     gain_min_q     <= pwdata[calrec_pkg::GAIN_W-1:0];
        calrec_pkg::REG_GAIN_MAX:     gain_max_q     <= pwdata[calrec_pkg::GAIN_W-1:0];
        calrec_pkg::REG_GAIN_DEFAULT: gain_default_q <= pwdata[calrec_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      calrec_pkg::REG_GAIN_MIN:     prdata = 32'(gain_min_q);
      calrec_pkg::REG_GAIN_MAX:     prdata = 32'(gain_max_q);
      calrec_pkg::REG_GAIN_DEFAULT: prdata = 32'(gain_default_q);
      default:                      prdata = 32'd0;
    endcase
  end

  // the held word moves on when it makes no result, or when the output
  // stage has room for its result
  assign advance    = in_v_q && (!has_result || can_load);
  assign in_ready_o = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      word_q <= word_in_i;
    end
  end

  // record state, crc fold, fault order and build clamp
  calrec_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .op_i           (op_q),
    .word_i         (word_q),
    .gain_min_i     (gain_min_q),
    .gain_max_i     (gain_max_q),
    .gain_default_i (gain_default_q),
    .has_result_o   (has_result),
    .result_o       (result)
  );

  // result register; a build result plays out as four words
  calrec_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_req_i  (in_v_q && has_result),
    .result_i    (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_out_o  (word_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for calibration_record_crc_check, record
// check and record build words over valid/ready, gain limits set over apb
// depends on calrec_pkg and the calibration_record_crc_check rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // input op codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  // cycles without any accepted word before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // receiver hold-off used to back the block up
  localparam int unsigned HOLDOFF_CYCLES = 150;

  // one output word as the block should present it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  status;
    logic        last;
  } gain_word_t;

  // predicted behavior of the block plus the queue of words still owed
  class record_scoreboard;
    logic [13:0] gain_min;
    logic [13:0] gain_max;
    logic [13:0] gain_default;
    logic [1:0]  word_pos;
    logic [31:0] crc_acc;
    logic [2:0]  fault;
    logic [31:0] held_gain;
    gain_word_t  awaited_words[$];
    int          errors;

    function new();
      gain_min     = 14'd1;
      gain_max     = 14'd9999;
      gain_default = 14'd100;
      errors       = 0;
      clear_check();
    endfunction

    // reflected crc-32 fold of one word, low byte first
    static function logic [31:0] fold_crc(logic [31:0] crc, logic [31:0] w);
      logic [31:0] c;
      c = crc;
      for (int b = 0; b < 4; b++) begin
        c ^= {24'h0, w[8*b +: 8]};
        for (int k = 0; k < 8; k++) begin
          c = c[0] ? ((c >> 1) ^ calrec_pkg::CRC_POLY) : (c >> 1);
        end
      end
      return c;
    endfunction

    function void clear_check();
      word_pos  = 2'd0;
      crc_acc   = calrec_pkg::CRC_INIT;
      fault     = calrec_pkg::ST_OK;
      held_gain = 32'h0;
    endfunction

    function void set_gain_reg(logic [1:0] idx, logic [13:0] val);
      case (idx)
        calrec_pkg::REG_GAIN_MIN:     gain_min = val;
        calrec_pkg::REG_GAIN_MAX:     gain_max = val;
        calrec_pkg::REG_GAIN_DEFAULT: gain_default = val;
        default:                      ;
      endcase
    endfunction

    function void push_word(logic [31:0] w, logic [2:0] st, logic lst);
      gain_word_t r;
      r.word   = w;
      r.status = st;
      r.last   = lst;
      awaited_words.push_back(r);
    endfunction

    // note one accepted input word and queue whatever it produces
    function void accept_word(logic op, logic [31:0] w);
      logic [31:0] g;
      logic [31:0] crc;
      logic [2:0]  st;
      if (op == OP_BUILD) begin
        // floor is tested first, so inverted bounds still clamp sensibly
        if (w < gain_min) begin
          g = {18'h0, gain_min};
        end else if (w > gain_max) begin
          g = {18'h0, gain_max};
        end else begin
          g = w;
        end
        crc = ~fold_crc(fold_crc(fold_crc(calrec_pkg::CRC_INIT, calrec_pkg::REC_MAGIC),
                                 calrec_pkg::REC_VERSION), g);
        clear_check();
        push_word(calrec_pkg::REC_MAGIC, calrec_pkg::ST_OK, 1'b0);
        push_word(calrec_pkg::REC_VERSION, calrec_pkg::ST_OK, 1'b0);
        push_word(g, calrec_pkg::ST_OK, 1'b0);
        push_word(crc, calrec_pkg::ST_OK, 1'b1);
        return;
      end
      case (word_pos)
        2'd0: begin
          if (fault == calrec_pkg::ST_OK && w != calrec_pkg::REC_MAGIC)
            fault = calrec_pkg::ST_BAD_MAGIC;
        end
        2'd1: begin
          if (fault == calrec_pkg::ST_OK && w != calrec_pkg::REC_VERSION)
            fault = calrec_pkg::ST_BAD_VERSION;
        end
        2'd2: begin
          held_gain = w;
          if (fault == calrec_pkg::ST_OK && (w < gain_min || w > gain_max))
            fault = calrec_pkg::ST_RANGE;
        end
        default: begin
          st = fault;
          if (st == calrec_pkg::ST_OK && ~crc_acc != w) st = calrec_pkg::ST_CRC;
          push_word((st == calrec_pkg::ST_OK) ? held_gain : {18'h0, gain_default},
                    st, 1'b1);
          clear_check();
          return;
        end
      endcase
      crc_acc  = fold_crc(crc_acc, w);
      word_pos = word_pos + 2'd1;
    endfunction

    // compare one accepted output word with the oldest one owed
    function void check_word_out(logic [31:0] w, logic [2:0] st, logic lst);
      gain_word_t e;
      if (awaited_words.size() == 0) begin
        $error("unexpected output word %08h status %0d last %0b", w, st, lst);
        errors++;
        return;
      end
      e = awaited_words.pop_front();
      if (w !== e.word) begin
        $error("word_out: expected %08h, actual %08h", e.word, w);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and block ports; the driven ones are known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = 4'h0;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        op_i        = OP_CHECK;
  logic [31:0] word_in_i   = 32'h0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] word_out_o;
  logic [2:0]  status_o;
  logic        last_o;

  record_scoreboard sb = new();

  // idle percentages of the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // request from the stimulus for one long receiver hold-off
  bit          holdoff_req    = 1'b0;
  int unsigned items_sent     = 0;

  calibration_record_crc_check i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .word_in_i   (word_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_out_o  (word_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // output side: ready changes on the falling edge, with an optional long
  // hold-off counted here so the sender keeps pushing into a full block
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall_left  = HOLDOFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // every accepted output word is checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word_out(word_out_o, status_o, last_o);
    end
  end

  // hang detector: any accepted word on either side restarts the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {18'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_gain_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [13:0] lo, logic [13:0] hi, logic [13:0] dflt);
    write_reg(calrec_pkg::REG_GAIN_MIN, lo);
    write_reg(calrec_pkg::REG_GAIN_MAX, hi);
    write_reg(calrec_pkg::REG_GAIN_DEFAULT, dflt);
  endtask

  // offer one input word; valid stays up from word to word unless the
  // sender decides to idle first
  task automatic send_word(logic op, logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    word_in_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_word(op, w);
    items_sent++;
  endtask

  // stop sending, wait for every owed word, then let the pipeline settle
  // since check words one to three leave nothing behind in the queue
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // four check words; crc over the words actually sent, then optionally
  // flipped to force a mismatch
  task automatic send_record(logic [31:0] magic, logic [31:0] version,
                             logic [31:0] gain, logic [31:0] crc_flip);
    logic [31:0] crc;
    crc = ~record_scoreboard::fold_crc(record_scoreboard::fold_crc(
            record_scoreboard::fold_crc(calrec_pkg::CRC_INIT, magic), version), gain);
    send_word(OP_CHECK, magic);
    send_word(OP_CHECK, version);
    send_word(OP_CHECK, gain);
    send_word(OP_CHECK, crc ^ crc_flip);
  endtask

  // gain candidates biased toward the current limits and their neighbors
  function automatic logic [31:0] pick_gain();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = {18'h0, sb.gain_min};
    hi = {18'h0, sb.gain_max};
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      2:       return lo - 32'd1;
      3:       return hi + 32'd1;
      4:       return $urandom_range(16383);
      5:       return $urandom;
      default: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(16383);
    endcase
  endfunction

  function automatic logic [31:0] flip_one_bit(int unsigned pct);
    return ($urandom_range(99) < pct) ? (32'h1 << $urandom_range(31)) : 32'h0;
  endfunction

  // one random unit: mostly full records, some builds, some broken input
  task automatic random_unit();
    int unsigned pick;
    int unsigned n;
    logic [31:0] rec [4];
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_record(calrec_pkg::REC_MAGIC ^ flip_one_bit(10),
                  calrec_pkg::REC_VERSION ^ flip_one_bit(10),
                  pick_gain(), flip_one_bit(12));
    end else if (pick < 80) begin
      send_word(OP_BUILD, ($urandom_range(99) < 70) ? pick_gain() : $urandom);
    end else if (pick < 90) begin
      // record cut short, then a build abandons it
      rec[0] = calrec_pkg::REC_MAGIC;
      rec[1] = calrec_pkg::REC_VERSION;
      rec[2] = pick_gain();
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send_word(OP_CHECK, rec[i]);
      send_word(OP_BUILD, pick_gain());
    end else begin
      // stray check words push the record framing out of step
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send_word(OP_CHECK, $urandom);
    end
  endtask

  task automatic random_items(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_unit();
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on reset limits (1 .. 9999, default 100)
    set_idling(0, 0);
    send_record(calrec_pkg::REC_MAGIC, calrec_pkg::REC_VERSION, 32'd9999, 32'h0);
    // magic, version and gain wrong: magic wins
    send_record(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    // version wrong with gain and crc also wrong: version wins
    send_record(calrec_pkg::REC_MAGIC, 32'h2, 32'd10000, 32'h8000_0000);
    // gain under the floor with a good crc
    send_record(calrec_pkg::REC_MAGIC, calrec_pkg::REC_VERSION, 32'h0, 32'h0);
    // clean fields, crc off by one bit
    send_record(calrec_pkg::REC_MAGIC, calrec_pkg::REC_VERSION, 32'd500, 32'h1);
    // builds clamped at both ends
    send_word(OP_BUILD, 32'h0);
    send_word(OP_BUILD, 32'hFFFF_FFFF);
    // partial check dropped by a build
    send_word(OP_CHECK, calrec_pkg::REC_MAGIC);
    send_word(OP_CHECK, calrec_pkg::REC_VERSION);
    send_word(OP_BUILD, 32'd5000);
    drain();

    // wide limits, zero default, no idling
    configure(14'd0, 14'd9999, 14'd0);
    set_idling(0, 0);
    random_items(55);
    drain();

    // narrow window, slow sender
    configure(14'd500, 14'd600, 14'd9999);
    set_idling(69, 0);
    random_items(55);
    drain();

    // inverted bounds, slow receiver
    configure(14'd700, 14'd200, 14'd16383);
    set_idling(0, 69);
    random_items(55);
    drain();

    // single-point window, both sides idling, sender pauses midway for a
    // full drain
    configure(14'd0, 14'd0, 14'd12345);
    set_idling(26, 26);
    random_items(27);
    drain();
    random_items(28);
    drain();

    // receiver holds off while the sender keeps offering, so the block
    // backs up and stalls its input
    configure(14'd9999, 14'd16383, 14'd1);
    set_idling(0, 0);
    holdoff_req = 1'b1;
    random_items(30);
    drain();

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.awaited_words.size() != 0) begin
        $error("%0d output words never arrived", sb.awaited_words.size());
      end
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
